// File: design/bpps_pkg.sv
// ----------------------------------------------------------------------------
// bpps_pkg
// Shared types and constants of the Blinn-Phong pixel shader.
// ----------------------------------------------------------------------------
package bpps_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_LIGHT_DIR_X = 3'd0;
  localparam logic [2:0] CFG_LIGHT_DIR_Y = 3'd1;
  localparam logic [2:0] CFG_LIGHT_DIR_Z = 3'd2;
  localparam logic [2:0] CFG_LIGHT_RED   = 3'd3;
  localparam logic [2:0] CFG_LIGHT_GREEN = 3'd4;
  localparam logic [2:0] CFG_LIGHT_BLUE  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_LIGHT_DIR_X = 16'hC000;
  localparam logic [15:0] RST_LIGHT_DIR_Y = 16'h0000;
  localparam logic [15:0] RST_LIGHT_DIR_Z = 16'h0000;
  localparam logic [15:0] RST_LIGHT_COL   = 16'd19661;

  // Lighting weights scaled by 2^32: ambient 0.4, diffuse 0.7, specular 0.001
  localparam logic [30:0] KA_C = 31'd1717986918;
  localparam logic [31:0] KD_C = 32'd3006477107;
  localparam logic [22:0] KS_C = 23'd4294967;

  localparam logic [16:0] OUT_MAX = 17'h1FFFF;

  // Half-vector length unit: square root of |H|^2 after reset and after each direction write
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_RUN
  } sq_state_t;

endpackage

// File: design/blinn_phong_pixel_shade.sv
// ----------------------------------------------------------------------------
// blinn_phong_pixel_shade
// Per-pixel Blinn-Phong shading of a stream of surface normals.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the whole pipeline holds while a finished
//   result waits on out_ready.
// Reset: synchronous, active low; registers take their reset light, then the
//   half-vector length unit loads |H|^2 and runs its square root with
//   in_ready low. The same run follows every light direction write.
module blinn_phong_pixel_shade #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel: one normal per transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  // result channel: one shaded color per transaction
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [16:0] out_shade_red,
  output logic        [16:0] out_shade_green,
  output logic        [16:0] out_shade_blue,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int F     = FRAC_BITS;
  // width of Lz + ONE, signed
  localparam int HZW   = (F + 2 > 17) ? F + 2 : 17;
  localparam int PW    = 16 + HZW;          // dot product terms
  localparam int SW    = PW + 2;            // dot product sums
  localparam int H2W   = 2 * HZW + 1;       // |H|^2
  localparam int HLW   = (H2W + 1) / 2;     // |H|
  localparam int QW    = F + 3;             // clamped cosine, up to 4.0
  localparam int XW    = SW + HLW + F;      // divider remainder
  localparam int DFW   = SW - F;            // diffuse term
  localparam int C2W   = F + 5;
  localparam int C4W   = F + 9;
  localparam int SPW   = F + 17;            // specular term
  localparam int SUMW  = SW + 36;           // weighted factor sum
  localparam int FW    = SUMW - 32;         // lighting factor
  localparam int OPW   = 16 + FW;           // channel product
  localparam int DVN   = F + 2;             // divider stages
  localparam int CNTW  = $clog2(HLW + 1);

  localparam logic signed [HZW-1:0] ONE_V = {{(HZW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [QW-1:0]         CAP_V = {1'b1, {(QW-1){1'b0}}};
  localparam logic [H2W-1:0]        SQ_BIT0 = H2W'(1) << (2 * (HLW - 1));
  localparam logic [CNTW-1:0]       SQ_LAST = CNTW'(HLW - 1);

  // --------------------------------------------------------------------------
  // Configuration registers; always ready, an accepted write takes effect in the next cycle
  // --------------------------------------------------------------------------
  logic signed [15:0] light_dir_x_r, light_dir_y_r, light_dir_z_r;
  logic        [15:0] light_red_r, light_green_r, light_blue_r;
  logic               cfg_wr;
  logic               dir_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign dir_wr    = cfg_wr && (cfg_index == bpps_pkg::CFG_LIGHT_DIR_X ||
                                cfg_index == bpps_pkg::CFG_LIGHT_DIR_Y ||
                                cfg_index == bpps_pkg::CFG_LIGHT_DIR_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_dir_x_r <= bpps_pkg::RST_LIGHT_DIR_X;
      light_dir_y_r <= bpps_pkg::RST_LIGHT_DIR_Y;
      light_dir_z_r <= bpps_pkg::RST_LIGHT_DIR_Z;
      light_red_r   <= bpps_pkg::RST_LIGHT_COL;
      light_green_r <= bpps_pkg::RST_LIGHT_COL;
      light_blue_r  <= bpps_pkg::RST_LIGHT_COL;
    end else if (cfg_wr) begin
      // drop writes beyond the register list
      case (cfg_index)
        bpps_pkg::CFG_LIGHT_DIR_X: light_dir_x_r <= cfg_data;
        bpps_pkg::CFG_LIGHT_DIR_Y: light_dir_y_r <= cfg_data;
        bpps_pkg::CFG_LIGHT_DIR_Z: light_dir_z_r <= cfg_data;
        bpps_pkg::CFG_LIGHT_RED:   light_red_r   <= cfg_data;
        bpps_pkg::CFG_LIGHT_GREEN: light_green_r <= cfg_data;
        bpps_pkg::CFG_LIGHT_BLUE:  light_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Half vector z component: Lz + 1.0
  logic signed [HZW-1:0] hz;
  assign hz = {{(HZW-16){light_dir_z_r[15]}}, light_dir_z_r} + ONE_V;

  // --------------------------------------------------------------------------
  // Half-vector length: |H|^2 once per direction, then a digit-by-digit
  // square root, two bits of |H|^2 consumed per cycle
  // --------------------------------------------------------------------------
  bpps_pkg::sq_state_t     sq_state_r, sq_state_nxt;
  logic [CNTW-1:0]         sq_cnt_r, sq_cnt_nxt;
  logic [H2W-1:0]          sq_x_r, sq_x_nxt;
  logic [H2W-1:0]          sq_res_r, sq_res_nxt;
  logic [H2W-1:0]          sq_bit_r, sq_bit_nxt;
  logic [H2W-1:0]          h2_r, h2_nxt;
  logic signed [2*HZW-1:0] sqx, sqy, sqz;
  logic [H2W-1:0]          sq_trial;
  logic [HLW-1:0]          hlen;
  logic                    h2_zero;

  assign sqx = light_dir_x_r * light_dir_x_r;
  assign sqy = light_dir_y_r * light_dir_y_r;
  assign sqz = hz * hz;
  assign sq_trial = sq_res_r + sq_bit_r;
  assign hlen     = sq_res_r[HLW-1:0];
  assign h2_zero  = (h2_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_state_r <= bpps_pkg::SQ_LOAD;
      sq_cnt_r   <= '0;
    end else begin
      sq_state_r <= sq_state_nxt;
      sq_cnt_r   <= sq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r   <= sq_x_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    h2_r     <= h2_nxt;
  end

  always_comb begin
    sq_state_nxt = sq_state_r;
    sq_cnt_nxt   = sq_cnt_r;
    sq_x_nxt     = sq_x_r;
    sq_res_nxt   = sq_res_r;
    sq_bit_nxt   = sq_bit_r;
    h2_nxt       = h2_r;
    unique case (sq_state_r)
      bpps_pkg::SQ_IDLE: ;
      bpps_pkg::SQ_LOAD: begin
        h2_nxt       = H2W'($unsigned(sqx)) + H2W'($unsigned(sqy)) +
                       H2W'($unsigned(sqz));
        sq_x_nxt     = h2_nxt;
        sq_res_nxt   = '0;
        sq_bit_nxt   = SQ_BIT0;
        sq_cnt_nxt   = '0;
        sq_state_nxt = bpps_pkg::SQ_RUN;
      end
      bpps_pkg::SQ_RUN: begin
        if (sq_x_r >= sq_trial) begin
          sq_x_nxt   = sq_x_r - sq_trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == SQ_LAST) begin
          sq_state_nxt = bpps_pkg::SQ_IDLE;
        end
      end
      default: sq_state_nxt = bpps_pkg::SQ_LOAD;
    endcase
    // restart on any direction write
    if (dir_wr) begin
      sq_state_nxt = bpps_pkg::SQ_LOAD;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together; hold all while the
  // output register is full and not taken
  // --------------------------------------------------------------------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && (sq_state_r == bpps_pkg::SQ_IDLE);

  // Stage 1: dot product terms
  logic                  v1_r;
  logic signed [PW-1:0]  p_xl_r, p_yl_r, p_zl_r, p_zh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xl_r <= in_normal_x * light_dir_x_r;
      p_yl_r <= in_normal_y * light_dir_y_r;
      p_zl_r <= in_normal_z * light_dir_z_r;
      p_zh_r <= in_normal_z * hz;
    end
  end

  // Stage 2: N.L and N.H, diffuse term, specular enable
  logic                  v2_r;
  logic [DFW-1:0]        diff2_r;
  logic [XW-1:0]         num2_r;
  logic                  sok2_r;
  logic signed [SW-1:0]  ndl, ndh;
  logic [SW-1:0]         ndl_sh;

  assign ndl    = SW'(p_xl_r) + SW'(p_yl_r) + SW'(p_zl_r);
  assign ndh    = SW'(p_xl_r) + SW'(p_yl_r) + SW'(p_zh_r);
  assign ndl_sh = $unsigned(ndl) >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff2_r <= (ndl > 0) ? ndl_sh[DFW-1:0] : '0;
      sok2_r  <= (ndh > 0) && !h2_zero;
      num2_r  <= XW'($unsigned(ndh));
    end
  end

  // Stage 3: clamp check, cosine at or above 4.0 saturates
  // Divider stages 1..DVN: one quotient bit each, top bit first
  logic              dv_v_r    [0:DVN];
  logic              dv_done_r [0:DVN];
  logic [XW-1:0]     dv_rem_r  [0:DVN];
  logic [QW-1:0]     dv_q_r    [0:DVN];
  logic [DFW-1:0]    dv_diff_r [0:DVN];
  logic              ovf;

  assign ovf = (num2_r >= (XW'(hlen) << (F + 2)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_done_r[0] <= ovf || !sok2_r;
      dv_rem_r[0]  <= num2_r;
      dv_q_r[0]    <= (ovf && sok2_r) ? CAP_V : '0;
      dv_diff_r[0] <= diff2_r;
    end
  end

  for (genvar k = 0; k < DVN; k++) begin : g_div
    localparam int B = DVN - 1 - k;
    logic [XW-1:0] dsh;
    logic          take;
    assign dsh  = XW'(hlen) << B;
    assign take = !dv_done_r[k] && (dv_rem_r[k] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_done_r[k+1] <= dv_done_r[k];
        dv_rem_r[k+1]  <= take ? (dv_rem_r[k] - dsh) : dv_rem_r[k];
        dv_q_r[k+1]    <= dv_q_r[k] | (take ? (QW'(1) << B) : '0);
        dv_diff_r[k+1] <= dv_diff_r[k];
      end
    end
  end

  // Power stages: c^2, c^4, c^8, each truncating by FRAC_BITS
  logic               pv1_r, pv2_r, pv3_r;
  logic [C2W-1:0]     c2_r;
  logic [C4W-1:0]     c4_r;
  logic [SPW-1:0]     spec_r;
  logic [DFW-1:0]     pd1_r, pd2_r, pd3_r;
  logic [2*QW-1:0]    cc;
  logic [2*C2W-1:0]   cc2;
  logic [2*C4W-1:0]   cc4;
  logic [2*QW-1:0]    cc_sh;
  logic [2*C2W-1:0]   cc2_sh;
  logic [2*C4W-1:0]   cc4_sh;

  assign cc     = dv_q_r[DVN] * dv_q_r[DVN];
  assign cc_sh  = cc >> F;
  assign cc2    = c2_r * c2_r;
  assign cc2_sh = cc2 >> F;
  assign cc4    = c4_r * c4_r;
  assign cc4_sh = cc4 >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv1_r <= 1'b0;
      pv2_r <= 1'b0;
      pv3_r <= 1'b0;
    end else if (en) begin
      pv1_r <= dv_v_r[DVN];
      pv2_r <= pv1_r;
      pv3_r <= pv2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= cc_sh[C2W-1:0];
      c4_r   <= cc2_sh[C4W-1:0];
      spec_r <= cc4_sh[SPW-1:0];
      pd1_r  <= dv_diff_r[DVN];
      pd2_r  <= pd1_r;
      pd3_r  <= pd2_r;
    end
  end

  // Weight stage: diffuse and specular contributions
  logic                mv_r;
  logic [32+DFW-1:0]   kd_r;
  logic [23+SPW-1:0]   ks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= pv3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd_r <= bpps_pkg::KD_C * pd3_r;
      ks_r <= bpps_pkg::KS_C * spec_r;
    end
  end

  // Sum stage: factor = (ambient + diffuse + specular) >> 32
  logic              av_r;
  logic [FW-1:0]     fac_r;
  logic [SUMW-1:0]   fsum;

  assign fsum = SUMW'({bpps_pkg::KA_C, {F{1'b0}}}) + SUMW'(kd_r) + SUMW'(ks_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (en) begin
      av_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fac_r <= fsum[SUMW-1:32];
    end
  end

  // Output stage: scale each channel, saturate at the top
  logic            out_valid_r;
  logic [16:0]     shade_red_r, shade_green_r, shade_blue_r;
  logic [OPW-1:0]  pr, pg, pb;
  logic [OPW-1:0]  pr_sh, pg_sh, pb_sh;

  assign pr    = light_red_r * fac_r;
  assign pg    = light_green_r * fac_r;
  assign pb    = light_blue_r * fac_r;
  assign pr_sh = pr >> F;
  assign pg_sh = pg >> F;
  assign pb_sh = pb >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shade_red_r   <= (pr_sh > OPW'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX
                                                         : pr_sh[16:0];
      shade_green_r <= (pg_sh > OPW'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX
                                                         : pg_sh[16:0];
      shade_blue_r  <= (pb_sh > OPW'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX
                                                         : pb_sh[16:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shade_red   = shade_red_r;
  assign out_shade_green = shade_green_r;
  assign out_shade_blue  = shade_blue_r;

endmodule

// File: design/bpps_checker.sv
// ----------------------------------------------------------------------------
// bpps_checker
// Port-level checks of the Blinn-Phong pixel shader, bound to the top level.
// ----------------------------------------------------------------------------
module bpps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_shade_red,
  input logic [16:0] out_shade_green,
  input logic [16:0] out_shade_blue,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_shade_red) &&
    $stable(out_shade_green) && $stable(out_shade_blue))
    else $error("stalled result changed");

  // no result straight out of reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the half-vector length is recomputed after reset
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during length computation after reset");

  // a light direction write blocks new pixels for the recompute
  a_dir_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == bpps_pkg::CFG_LIGHT_DIR_X ||
     cfg_index == bpps_pkg::CFG_LIGHT_DIR_Y ||
     cfg_index == bpps_pkg::CFG_LIGHT_DIR_Z) |=> !in_ready)
    else $error("input ready right after a direction write");

endmodule

bind blinn_phong_pixel_shade bpps_checker u_bpps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_shade_red   (out_shade_red),
  .out_shade_green (out_shade_green),
  .out_shade_blue  (out_shade_blue),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .cfg_index       (cfg_index)
);

// File: sim/tb_blinn_phong_pixel_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blinn_phong_pixel_shade
// Streams surface normals through the shader under several light settings.
// Expected colors are predicted in fixed point and checked in order against
// every output transaction, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_blinn_phong_pixel_shade;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } normal_t;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } color_t;

  localparam int FB = 14;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_normal_x;
  logic signed [15:0] in_normal_y;
  logic signed [15:0] in_normal_z;
  logic out_valid;
  logic out_ready;
  logic [16:0] out_shade_red;
  logic [16:0] out_shade_green;
  logic [16:0] out_shade_blue;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  blinn_phong_pixel_shade dut (.*);

  // Light setting as seen by the predictor
  logic [15:0] light_regs [6];

  normal_t pending_normals[$];
  color_t expected_colors[$];
  int mismatch_count;
  int idle_cycles;
  bit no_idle;      // quiet stretch: no random gaps on either side
  bit sender_hold;  // pause the sender until the pipeline is empty

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Work out the shaded color of one normal under the current light
  function automatic color_t shade_normal(input normal_t n);
    longint lx, ly, lz, hz, ndl, ndh;
    logic [63:0] diff, spec, fac, h2, hlen, cap, c, c2, c4, v;
    color_t r;
    lx = longint'($signed(light_regs[bpps_pkg::CFG_LIGHT_DIR_X]));
    ly = longint'($signed(light_regs[bpps_pkg::CFG_LIGHT_DIR_Y]));
    lz = longint'($signed(light_regs[bpps_pkg::CFG_LIGHT_DIR_Z]));
    hz = lz + (longint'(1) << FB);
    ndl = longint'(n.nx) * lx + longint'(n.ny) * ly + longint'(n.nz) * lz;
    diff = 0;
    spec = 0;
    if (ndl > 0) diff = 64'(ndl) >> FB;
    h2 = 64'(lx * lx) + 64'(ly * ly) + 64'(hz * hz);
    if (h2 != 0) begin
      ndh = longint'(n.nx) * lx + longint'(n.ny) * ly + longint'(n.nz) * hz;
      if (ndh > 0) begin
        hlen = isqrt(h2);
        cap = 64'd1 << (FB + 2);
        // clamp the cosine for oversized normals
        if (hlen == 0 || 64'(ndh) / hlen >= cap) c = cap;
        else c = 64'(ndh) / hlen;
        c2 = (c * c) >> FB;
        c4 = (c2 * c2) >> FB;
        spec = (c4 * c4) >> FB;
      end
    end
    fac = ((64'(bpps_pkg::KA_C) << FB) + 64'(bpps_pkg::KD_C) * diff +
           64'(bpps_pkg::KS_C) * spec) >> 32;
    v = (64'(light_regs[bpps_pkg::CFG_LIGHT_RED]) * fac) >> FB;
    r.red = (v > 64'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX : v[16:0];
    v = (64'(light_regs[bpps_pkg::CFG_LIGHT_GREEN]) * fac) >> FB;
    r.green = (v > 64'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX : v[16:0];
    v = (64'(light_regs[bpps_pkg::CFG_LIGHT_BLUE]) * fac) >> FB;
    r.blue = (v > 64'(bpps_pkg::OUT_MAX)) ? bpps_pkg::OUT_MAX : v[16:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Append one normal to the pending queue
  task automatic add_normal(input normal_t n);
    pending_normals.insert(pending_normals.size(), n);
  endtask

  // Driver: hold each normal on the bus until the transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) void'(pending_normals.pop_front());
      if (in_valid && in_ready && pending_normals.size() > 0) begin
        // stay high with the next normal, unless the sender is held or a random gap applies
        if (!sender_hold && (no_idle || $urandom_range(99) >= 7)) begin
          {in_normal_x, in_normal_y, in_normal_z} <= pending_normals[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!(in_valid && in_ready) && pending_normals.size() > 0 &&
                   !sender_hold && (no_idle || $urandom_range(99) >= 7)) begin
        in_valid <= 1'b1;
        {in_normal_x, in_normal_y, in_normal_z} <= pending_normals[0];
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance, using the light that is active right now
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_colors.insert(expected_colors.size(),
                             shade_normal({in_normal_x, in_normal_y, in_normal_z}));
    end
  end

  // Monitor: random back-pressure and in-order compare
  always @(posedge clk) begin
    color_t exp_c;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("output transaction with nothing expected");
        end else begin
          exp_c = expected_colors.pop_front();
          if (out_shade_red !== exp_c.red)
            report_mismatch($sformatf("red got %0d exp %0d", out_shade_red, exp_c.red));
          if (out_shade_green !== exp_c.green)
            report_mismatch($sformatf("green got %0d exp %0d", out_shade_green,
                                      exp_c.green));
          if (out_shade_blue !== exp_c.blue)
            report_mismatch($sformatf("blue got %0d exp %0d", out_shade_blue,
                                      exp_c.blue));
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_blinn_phong_pixel_shade failed");
        $finish;
      end
    end
  end

  // Write one register; only called while the pipeline is empty
  task automatic write_light(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    light_regs[idx] = val;
  endtask

  task automatic wait_drained();
    while (pending_normals.size() != 0 || in_valid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    // mostly magnitudes up to 1.0, sometimes anything
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384);
      2: return 16'($urandom_range(16384));
      default: return 16'(-$signed($urandom_range(16384)));
    endcase
  endfunction

  task automatic set_light(input logic [15:0] lx, input logic [15:0] ly,
                           input logic [15:0] lz, input logic [15:0] r,
                           input logic [15:0] g, input logic [15:0] b);
    wait_drained();
    write_light(bpps_pkg::CFG_LIGHT_DIR_X, lx);
    write_light(bpps_pkg::CFG_LIGHT_DIR_Y, ly);
    write_light(bpps_pkg::CFG_LIGHT_DIR_Z, lz);
    write_light(bpps_pkg::CFG_LIGHT_RED, r);
    write_light(bpps_pkg::CFG_LIGHT_GREEN, g);
    write_light(bpps_pkg::CFG_LIGHT_BLUE, b);
  endtask

  task automatic push_random(input int count);
    repeat (count) add_normal({rand_comp(), rand_comp(), rand_comp()});
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bpps_pkg::CFG_LIGHT_DIR_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_normal_x = '0;
    in_normal_y = '0;
    in_normal_z = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    sender_hold = 1'b0;
    light_regs[bpps_pkg::CFG_LIGHT_DIR_X] = bpps_pkg::RST_LIGHT_DIR_X;
    light_regs[bpps_pkg::CFG_LIGHT_DIR_Y] = bpps_pkg::RST_LIGHT_DIR_Y;
    light_regs[bpps_pkg::CFG_LIGHT_DIR_Z] = bpps_pkg::RST_LIGHT_DIR_Z;
    light_regs[bpps_pkg::CFG_LIGHT_RED] = bpps_pkg::RST_LIGHT_COL;
    light_regs[bpps_pkg::CFG_LIGHT_GREEN] = bpps_pkg::RST_LIGHT_COL;
    light_regs[bpps_pkg::CFG_LIGHT_BLUE] = bpps_pkg::RST_LIGHT_COL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset light, field extremes, tilted and back-facing normals
    add_normal({16'sh0000, 16'sh0000, 16'sh0000});
    add_normal({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    add_normal({16'sh8000, 16'sh8000, 16'sh8000});
    add_normal({16'shC000, 16'sh0000, 16'sh0000});
    add_normal({16'sh4000, 16'sh0000, 16'sh0000});
    add_normal({16'shD2BF, 16'sh0000, 16'sh2D41});
    add_normal({16'sh0000, 16'sh0000, 16'sh4000});
    add_normal({16'sh8000, 16'sh7FFF, 16'sh0000});
    add_normal({16'sh7FFF, 16'sh8000, 16'sh7FFF});

    // Zero half vector: light straight into the viewer
    set_light(16'h0000, 16'h0000, 16'hC000, 16'hFFFF, 16'h0000, 16'h8000);
    add_normal({16'sh0000, 16'sh0000, 16'shC000});
    add_normal({16'sh0000, 16'sh0000, 16'sh8000});
    add_normal({16'sh0000, 16'sh0000, 16'sh4000});

    // Light along the view: large cosine, bright color saturates
    set_light(16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_normal({16'sh0000, 16'sh0000, 16'sh4000});
    add_normal({16'sh0000, 16'sh0000, 16'sh7FFF});
    add_normal({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    add_normal({16'sh0000, 16'sh0000, 16'shC000});

    // Extreme direction: large h2, tiny and negative components
    set_light(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h7FFF);
    add_normal({16'sh8000, 16'sh7FFF, 16'sh8000});
    add_normal({16'sh7FFF, 16'sh8000, 16'sh7FFF});
    add_normal({16'sh0001, 16'shFFFF, 16'sh0001});

    // Random phases: quiet stretch first, then random lights
    set_light(16'hC000, 16'h0000, 16'h0000, 16'd19661, 16'd19661, 16'd19661);
    no_idle = 1'b1;
    push_random(200);
    wait_drained();
    no_idle = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      set_light(rand_comp(), rand_comp(), rand_comp(), 16'($urandom),
                16'($urandom_range(32768)), 16'($urandom));
      push_random(80);
      // let the pipeline empty mid-stream with the sender held off
      while (pending_normals.size() > 40) @(posedge clk);
      sender_hold = 1'b1;
      while (expected_colors.size() != 0 || in_valid) @(posedge clk);
      sender_hold = 1'b0;
      push_random(70);
    end
    set_light(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_random(50);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_blinn_phong_pixel_shade passed");
    end else begin
      $display("tb_blinn_phong_pixel_shade failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bpps_pkg.sv
design/blinn_phong_pixel_shade.sv
design/bpps_checker.sv
sim/tb_blinn_phong_pixel_shade.sv
